// ----- design/deadline_sleep_table_macros.svh -----
// Assertion macros for the deadline sleep table.
// Used by the top level; the clock i_clk and reset i_rst_n must be in scope.
`ifndef DEADLINE_SLEEP_TABLE_MACROS_SVH
`define DEADLINE_SLEEP_TABLE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define DST_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deadline_sleep_table: same-cycle check failed");
// Next-cycle implication.
`define DST_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deadline_sleep_table: next-cycle check failed");
`else
`define DST_ASSERT_IMP(label, ante, cons)
`define DST_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ----- design/dst_pkg.sv -----
// Shared types and constants of the deadline sleep table.
// No dependencies; imported by the top level and by dst_seq.
`timescale 1ns / 1ps
`default_nettype none

package dst_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int DELAY_W     = 32;
    localparam int TIME_W      = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int WORD_W      = ID_BITS + TIME_W;
    localparam int MODE_W      = 2;
    localparam int KIND_W      = 3;
    localparam int IN_DATA_W   = ((ID_BITS + DELAY_W + 1 + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((ID_BITS + CNT_W + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_SLEEP  = 2'd0,
        MODE_TICK   = 2'd1,
        MODE_CANCEL = 2'd2
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        KIND_PARKED    = 3'd0,
        KIND_YIELDED   = 3'd1,
        KIND_REFUSED   = 3'd2,
        KIND_FULL      = 3'd3,
        KIND_CANCELLED = 3'd4,
        KIND_ABSENT    = 3'd5,
        KIND_WOKEN     = 3'd6,
        KIND_NONE_DUE  = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_TAIL,
        ST_MOVE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_kind              kind;
        logic [ID_BITS-1:0] id;
        logic [CNT_W-1:0]   occ;
        logic               last;
    } t_res;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } t_mem_req;

endpackage

`default_nettype wire

// ----- design/deadline_sleep_table.sv -----
// Top level of the deadline sleep table: stream ports, output register, RAM.
// Depends on dst_pkg, dst_ram, dst_seq and deadline_sleep_table_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

//  Channel   Direction  Handshake                      Carries
//  s_axis    in         s_axis_tvalid / s_axis_tready  requests: sleep, tick, cancel
//  m_axis    out        m_axis_tvalid / m_axis_tready  results, tlast on the final one
//
//  A sleep request goes from idle to the emit state. A cancel reads and checks each entry in
//  turn, refills a match that is not the tail from the tail, passes a last read state if
//  nothing matches, and then delivers its result. A tick examines every entry once, refills
//  each woken entry that is not the tail from the tail, and ends with a read state and the
//  emit state. The single read port of the table RAM with its registered read sets this order.
//  Reset clears time, occupancy and the output valid; the table contents need no clearing.
//  A stalled output holds the scan in place; a new request is taken only when idle.

module deadline_sleep_table (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [7:0] thread_id, [39:8] delay_ticks, [40] thread_killed, rest zero.
    input  wire logic [dst_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [1:0] mode.
    input  wire logic [dst_pkg::MODE_W-1:0]        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [7:0] woken_id, [12:8] occupancy, rest zero.
    output logic      [dst_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [2:0] kind.
    output logic      [dst_pkg::KIND_W-1:0]        m_axis_tuser,
    output logic                                   m_axis_tlast
);

    import dst_pkg::*;

    `include "deadline_sleep_table_macros.svh"

    t_mem_req          w_mem;
    logic [WORD_W-1:0] w_rdata;
    t_res              w_res;
    logic              w_push;
    logic              w_slot_free;

    // One result register parts the scan from the downstream consumer.
    logic r_ovalid;
    t_res r_out;

    assign w_slot_free = !r_ovalid || m_axis_tready;

    dst_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_re    (w_mem.re),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rdata)
    );

    dst_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_mode      (s_axis_tuser),
        .i_id        (s_axis_tdata[ID_BITS-1:0]),
        .i_delay     (s_axis_tdata[ID_BITS+DELAY_W-1:ID_BITS]),
        .i_killed    (s_axis_tdata[ID_BITS+DELAY_W]),
        .i_slot_free (w_slot_free),
        .o_push      (w_push),
        .o_res       (w_res),
        .o_mem       (w_mem),
        .i_rdata     (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_push) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {{(OUT_DATA_W - ID_BITS - CNT_W){1'b0}}, r_out.occ, r_out.id};

    // A new result is only produced when the output register can take it.
    `DST_ASSERT_IMP(a_push_has_room, w_push, w_slot_free)
    // Every kind other than a wake ends its request.
    `DST_ASSERT_IMP(a_single_is_last, r_ovalid && (r_out.kind != KIND_WOKEN), r_out.last)
    // A tick always starts a scan, so the input side closes right after it.
    `DST_ASSERT_NXT(a_tick_busy,
        s_axis_tvalid && s_axis_tready && (t_mode'(s_axis_tuser) == MODE_TICK),
        !s_axis_tready)
    // Occupancy never exceeds the table depth.
    `DST_ASSERT_IMP(a_occ_bound, r_ovalid, r_out.occ <= CNT_W'(TABLE_DEPTH))

endmodule

`default_nettype wire

// ----- design/dst_ram.sv -----
// Simple dual-port synchronous RAM with a registered read.
// Generic; holds the sleep table entries. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/dst_seq.sv -----
// Sequencer of the deadline sleep table: time, occupancy and the table scans.
// Depends on dst_pkg; drives the request port of the table RAM.
`timescale 1ns / 1ps
`default_nettype none

module dst_seq (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [dst_pkg::MODE_W-1:0]  i_mode,
    input  wire logic [dst_pkg::ID_BITS-1:0] i_id,
    input  wire logic [dst_pkg::DELAY_W-1:0] i_delay,
    input  wire logic                      i_killed,
    input  wire logic                      i_slot_free,
    output logic                           o_push,
    output dst_pkg::t_res                  o_res,
    output dst_pkg::t_mem_req              o_mem,
    input  wire logic [dst_pkg::WORD_W-1:0]  i_rdata
);

    import dst_pkg::*;

    t_state             r_state, n_state;
    t_mode              r_mode, n_mode;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [TIME_W-1:0]  r_time, n_time;
    logic               r_pend_valid, n_pend_valid;
    logic [ID_BITS-1:0] r_pend_id, n_pend_id;
    logic [CNT_W-1:0]   r_pend_occ, n_pend_occ;
    logic [ID_BITS-1:0] r_id, n_id;
    t_res               r_res, n_res;

    logic [TIME_W-1:0]  rd_wake;
    logic [ID_BITS-1:0] rd_thread;
    logic [CNT_W-1:0]   count_m1;
    logic               at_tail;

    assign rd_wake   = i_rdata[TIME_W-1:0];
    assign rd_thread = i_rdata[WORD_W-1:TIME_W];
    assign count_m1  = r_count - CNT_W'(1);
    assign at_tail   = (r_idx == count_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_time       <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_time       <= n_time;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_idx      <= n_idx;
        r_pend_id  <= n_pend_id;
        r_pend_occ <= n_pend_occ;
        r_id       <= n_id;
        r_res      <= n_res;
    end

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_idx        = r_idx;
        n_count      = r_count;
        n_time       = r_time;
        n_pend_valid = r_pend_valid;
        n_pend_id    = r_pend_id;
        n_pend_occ   = r_pend_occ;
        n_id         = r_id;
        n_res        = r_res;
        o_ready      = 1'b0;
        o_push       = 1'b0;
        o_res        = r_res;
        o_mem.we     = 1'b0;
        o_mem.waddr  = r_idx[IDX_W-1:0];
        o_mem.wdata  = i_rdata;
        o_mem.re     = 1'b0;
        o_mem.raddr  = r_idx[IDX_W-1:0];

        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_id = i_id;
                    case (t_mode'(i_mode))
                        MODE_SLEEP: begin
                            n_state    = ST_EMIT;
                            n_res.last = 1'b1;
                            n_res.id   = '0;
                            n_res.occ  = r_count;
                            if (i_delay == '0) begin
                                n_res.kind = KIND_YIELDED;
                            end else if (i_killed) begin
                                n_res.kind = KIND_REFUSED;
                            end else if (r_count >= CNT_W'(TABLE_DEPTH)) begin
                                n_res.kind = KIND_FULL;
                            end else begin
                                o_mem.we    = 1'b1;
                                o_mem.waddr = r_count[IDX_W-1:0];
                                o_mem.wdata = {i_id, r_time + TIME_W'(i_delay)};
                                n_count     = r_count + CNT_W'(1);
                                n_res.kind  = KIND_PARKED;
                                n_res.id    = i_id;
                                n_res.occ   = r_count + CNT_W'(1);
                            end
                        end
                        MODE_TICK: begin
                            n_time       = r_time + TIME_W'(1);
                            n_idx        = '0;
                            n_pend_valid = 1'b0;
                            n_mode       = MODE_TICK;
                            n_state      = ST_READ;
                        end
                        MODE_CANCEL: begin
                            n_idx   = '0;
                            n_mode  = MODE_CANCEL;
                            n_state = ST_READ;
                        end
                        default: begin
                            // Unused mode: dropped without a result.
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (r_idx < r_count) begin
                    o_mem.re = 1'b1;
                    n_state  = ST_CHECK;
                end else begin
                    n_state    = ST_EMIT;
                    n_res.last = 1'b1;
                    n_res.occ  = r_count;
                    n_res.id   = '0;
                    if (r_mode == MODE_TICK) begin
                        if (r_pend_valid) begin
                            n_res.kind = KIND_WOKEN;
                            n_res.id   = r_pend_id;
                            n_res.occ  = r_pend_occ;
                        end else begin
                            n_res.kind = KIND_NONE_DUE;
                        end
                    end else begin
                        n_res.kind = KIND_ABSENT;
                    end
                end
            end
            ST_CHECK: begin
                if (r_mode == MODE_TICK) begin
                    if (rd_wake <= r_time) begin
                        // The previous wake is sent on only now that another follows.
                        if (!r_pend_valid || i_slot_free) begin
                            o_push       = r_pend_valid;
                            o_res.kind   = KIND_WOKEN;
                            o_res.id     = r_pend_id;
                            o_res.occ    = r_pend_occ;
                            o_res.last   = 1'b0;
                            n_pend_valid = 1'b1;
                            n_pend_id    = rd_thread;
                            n_pend_occ   = count_m1;
                            n_count      = count_m1;
                            n_state      = at_tail ? ST_READ : ST_TAIL;
                        end
                    end else begin
                        n_idx   = r_idx + CNT_W'(1);
                        n_state = ST_READ;
                    end
                end else begin
                    if (rd_thread == r_id) begin
                        n_res.kind = KIND_CANCELLED;
                        n_res.id   = r_id;
                        n_res.occ  = count_m1;
                        n_res.last = 1'b1;
                        n_count    = count_m1;
                        n_state    = at_tail ? ST_EMIT : ST_TAIL;
                    end else begin
                        n_idx   = r_idx + CNT_W'(1);
                        n_state = ST_READ;
                    end
                end
            end
            ST_TAIL: begin
                // The count is already decremented, so it addresses the old tail.
                o_mem.re    = 1'b1;
                o_mem.raddr = r_count[IDX_W-1:0];
                n_state     = ST_MOVE;
            end
            ST_MOVE: begin
                o_mem.we = 1'b1;
                n_state  = (r_mode == MODE_TICK) ? ST_READ : ST_EMIT;
            end
            ST_EMIT: begin
                if (i_slot_free) begin
                    o_push  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
